[design/scfla_pkg.sv]
package scfla_pkg;

  localparam int unsigned HeapBytes  = 262144;
  localparam int unsigned NumClasses = 377;
  localparam int unsigned HeapWords  = HeapBytes / 8;
  localparam int unsigned WordW      = 16;
  localparam int unsigned WidxW      = $clog2(HeapWords);
  localparam int unsigned ClsW       = $clog2(NumClasses);
  localparam int unsigned LinkW      = WidxW + 1;

  localparam logic [0:0] CmdAlloc = 1'b0;
  localparam logic [0:0] CmdFree  = 1'b1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNoMemory = 2'd1;
  localparam logic [1:0] StatusTooLarge = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StAllocHead,
    StCarve,
    StAllocLink,
    StAllocDone,
    StFreeRead,
    StFreeCheck,
    StFreeHead,
    StFreeDone
  } state_e;

  function automatic logic [ClsW:0] size_class_of(input logic [15:0] bytes);
    logic [16:0] t;
    if (bytes <= 16'd1024) begin
      t = ({1'b0, bytes} + 17'd7) >> 3;
    end else begin
      t = ({1'b0, bytes} + 17'd127 + 17'(120 << 7)) >> 7;
    end
    return t[ClsW:0];
  endfunction

  function automatic logic [15:0] class_bytes(input logic [ClsW-1:0] cls);
    if (cls <= ClsW'(128)) begin
      return 16'({cls, 3'b000});
    end
    return 16'd1024 + 16'({cls - ClsW'(128), 7'd0});
  endfunction

  // blocks per carve run, by class size
  function automatic logic [7:0] run_blocks(input logic [15:0] ks);
    if (ks <= 16'd64) return 8'd128;
    if (ks <= 16'd128) return 8'd32;
    if (ks <= 16'd1024) return 8'd8;
    if (ks <= 16'd4096) return 8'd16;
    return 8'd1;
  endfunction

endpackage

[design/size_class_free_list_allocator_core.sv]
// allocate from a nonempty list: read class head, relink, then strobe done;
// a refill first carves a run of 1 to 128 blocks; free: read tag, check, push
// onto the class list, then strobe done; rejected or ignored ones finish sooner
// throughput: one transaction at a time, busy is high until the strobe
// class heads sit in a 377 x 16 memory, heap words in a 32768 x 16 memory
// reset: async active low, a clearing pass over all 377 class heads
// follows reset with busy high; results always go out, no stall
module size_class_free_list_allocator_core import scfla_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cmd_i,
  input  logic [14:0] request_bytes_i,
  input  logic [17:0] payload_address_i,
  output logic        done_o,
  output logic [17:0] granted_address_o,
  output logic [1:0]  status_o
);

  logic [LinkW-1:0] head_mem [NumClasses];
  logic [WordW-1:0] heap_mem [HeapWords];

  state_e state_q, state_d;
  logic [ClsW-1:0]  cls_q, cls_d;
  logic [WidxW-1:0] blk_q, blk_d;
  logic [LinkW-1:0] bump_q, bump_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [7:0]       nblk_q, nblk_d;
  logic [WidxW-1:0] kw_q, kw_d;
  logic [ClsW-1:0]  clr_q;
  logic             clr_busy_q;
  logic             done_q, done_d;
  logic [17:0]      addr_q, addr_d;
  logic [1:0]       stat_q, stat_d;

  logic [LinkW-1:0] head_rd_q;
  logic [WordW-1:0] heap_rd_q;
  logic             hd_we, hp_we;
  logic [ClsW-1:0]  hd_waddr, hd_raddr;
  logic [LinkW-1:0] hd_wdata;
  logic [WidxW-1:0] hp_waddr, hp_raddr;
  logic [WordW-1:0] hp_wdata;

  logic [ClsW:0]  req_cls;
  logic [15:0]    ks;
  logic [7:0]     nb;
  logic [LinkW:0] run_words, avail;
  logic [WidxW-1:0] carve_w;
  logic           fault_ok;

  always_ff @(posedge clk_i) begin
    if (hd_we) head_mem[hd_waddr] <= hd_wdata;
    head_rd_q <= head_mem[hd_raddr];
    if (hp_we) heap_mem[hp_waddr] <= hp_wdata;
    heap_rd_q <= heap_mem[hp_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      bump_q     <= '0;
      done_q     <= 1'b0;
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      state_q <= state_d;
      bump_q  <= bump_d;
      done_q  <= done_d;
      if (clr_busy_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == ClsW'(NumClasses - 1)) clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q  <= cls_d;
    blk_q  <= blk_d;
    cnt_q  <= cnt_d;
    nblk_q <= nblk_d;
    kw_q   <= kw_d;
    addr_q <= addr_d;
    stat_q <= stat_d;
  end

  assign req_cls   = size_class_of({1'b0, request_bytes_i} + 16'd8);
  assign ks        = class_bytes(cls_q);
  assign nb        = run_blocks(ks);
  assign run_words = (LinkW+1)'(({9'd0, nb} * {1'b0, ks}) >> 3);
  assign avail     = (LinkW+1)'(HeapWords) - {1'b0, bump_q};
  assign carve_w   = blk_q;
  assign fault_ok  = (heap_rd_q != '0) && (heap_rd_q < WordW'(NumClasses));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start_i && !clr_busy_q) begin
          if (cmd_i == CmdAlloc) begin
            if (req_cls >= (ClsW+1)'(NumClasses)) state_d = StAllocDone;
            else state_d = StAllocHead;
          end else if (payload_address_i >= 18'd8 && payload_address_i[2:0] == 3'd0) begin
            state_d = StFreeRead;
          end else begin
            state_d = StFreeDone;
          end
        end
      end
      StAllocHead: begin
        if (head_rd_q != '0) state_d = StAllocLink;
        else if (run_words > avail) state_d = StAllocDone;
        else state_d = StCarve;
      end
      StCarve:     if (cnt_q + 8'd1 == nblk_q) state_d = StAllocLink;
      StAllocLink: state_d = StAllocDone;
      StFreeRead:  state_d = StFreeCheck;
      StFreeCheck: state_d = fault_ok ? StFreeHead : StFreeDone;
      StFreeHead:  state_d = StFreeDone;
      StAllocDone, StFreeDone: state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  always_comb begin
    cls_d    = cls_q;
    blk_d    = blk_q;
    bump_d   = bump_q;
    cnt_d    = cnt_q;
    nblk_d   = nblk_q;
    kw_d     = kw_q;
    addr_d   = addr_q;
    stat_d   = stat_q;
    done_d   = 1'b0;
    hd_we    = clr_busy_q;
    hd_waddr = clr_q;
    hd_wdata = '0;
    hd_raddr = cls_q;
    hp_we    = 1'b0;
    hp_waddr = blk_q;
    hp_wdata = '0;
    hp_raddr = blk_q;
    unique case (state_q)
      StIdle: begin
        addr_d = '0;
        stat_d = StatusOk;
        cls_d  = req_cls[ClsW-1:0];
        hd_raddr = req_cls[ClsW-1:0];
        blk_d  = WidxW'((payload_address_i >> 3) - 18'd1);
        hp_raddr = WidxW'((payload_address_i >> 3) - 18'd1);
        if (start_i && !clr_busy_q && cmd_i == CmdAlloc
            && req_cls >= (ClsW+1)'(NumClasses)) stat_d = StatusTooLarge;
      end
      StAllocHead: begin
        cnt_d  = '0;
        nblk_d = nb;
        kw_d   = WidxW'(ks >> 3);
        if (head_rd_q != '0) begin
          blk_d    = WidxW'(head_rd_q - 1'b1);
          hp_raddr = WidxW'(head_rd_q - 1'b1);
        end else if (run_words > avail) begin
          stat_d = StatusNoMemory;
        end else begin
          blk_d = bump_q[WidxW-1:0];
        end
      end
      StCarve: begin
        hp_we    = 1'b1;
        hp_waddr = carve_w;
        hp_wdata = (cnt_q + 8'd1 == nblk_q) ? '0 :
                   WordW'({1'b0, carve_w} + {1'b0, kw_q} + 1'b1);
        blk_d    = carve_w + kw_q;
        cnt_d    = cnt_q + 8'd1;
        if (cnt_q + 8'd1 == nblk_q) begin
          blk_d    = bump_q[WidxW-1:0];
          hp_raddr = bump_q[WidxW-1:0];
          bump_d   = bump_q + LinkW'(run_words);
        end
      end
      StAllocLink: begin
        hd_we    = 1'b1;
        hd_waddr = cls_q;
        hd_wdata = LinkW'(heap_rd_q);
        if (state_q == StAllocLink && cnt_q != '0 && cnt_q == nblk_q) begin
          hd_wdata = (nblk_q == 8'd1) ? '0 : LinkW'({1'b0, blk_q} + {1'b0, kw_q} + 1'b1);
        end
        hp_we    = 1'b1;
        hp_wdata = WordW'(cls_q);
        addr_d   = 18'({1'b0, blk_q} + 1'b1) << 3;
      end
      StFreeRead: begin
        hp_raddr = blk_q;
      end
      StFreeCheck: begin
        cls_d    = heap_rd_q[ClsW-1:0];
        hd_raddr = heap_rd_q[ClsW-1:0];
      end
      StFreeHead: begin
        hp_we    = 1'b1;
        hp_wdata = WordW'(head_rd_q);
        hd_we    = 1'b1;
        hd_waddr = cls_q;
        hd_wdata = LinkW'({1'b0, blk_q} + 1'b1);
      end
      StAllocDone, StFreeDone: done_d = 1'b1;
      default: ;
    endcase
  end

  assign busy_o            = (state_q != StIdle) || clr_busy_q;
  assign done_o            = done_q;
  assign granted_address_o = addr_q;
  assign status_o          = stat_q;

endmodule

[verif/scfla_checker.sv]
module scfla_checker import scfla_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        cmd_i,
  input  logic [14:0] request_bytes_i,
  input  logic [17:0] payload_address_i,
  input  logic        done_i,
  input  logic [17:0] granted_address_i,
  input  logic [1:0]  status_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [17:0] addr;
    logic [1:0]  status;
  } grant_t;

  grant_t      grant_q[$];
  int unsigned list_head[NumClasses];
  int unsigned heap_mem[HeapWords];
  int unsigned bump;

  initial begin
    errors_o = 0;
    bump = 0;
    foreach (list_head[i]) list_head[i] = 0;
  end

  assign pending_o = grant_q.size();

  function automatic int unsigned class_for(int unsigned bytes);
    if (bytes <= 1024) return (bytes + 7) >> 3;
    return (bytes + 127 + (120 << 7)) >> 7;
  endfunction

  function automatic int unsigned class_size(int unsigned cls);
    if (cls <= 128) return cls << 3;
    return 1024 + ((cls - 128) << 7);
  endfunction

  function automatic int unsigned carve_bytes(int unsigned ks);
    if (ks <= 64) return ks * 128;
    if (ks <= 128) return ks * 32;
    if (ks <= 1024) return ks * 8;
    if (ks <= 4096) return ks * 16;
    return ks;
  endfunction

  function automatic grant_t predict_grant(logic cmd, logic [14:0] req, logic [17:0] addr);
    grant_t      g;
    int unsigned cls, head, blk, ks, run, kw, n, w;
    g = '0;
    if (cmd == CmdAlloc) begin
      cls = class_for(int'(req) + 8);
      if (cls >= NumClasses) begin
        g.status = StatusTooLarge;
        return g;
      end
      head = list_head[cls];
      if (head == 0 || head > HeapWords) begin
        ks = class_size(cls);
        run = carve_bytes(ks);
        kw = ks >> 3;
        n = run / ks;
        if (run > (HeapWords - bump) * 8) begin
          g.status = StatusNoMemory;
          return g;
        end
        for (int unsigned i = 0; i < n; i++) begin
          w = bump + i * kw;
          heap_mem[w] = (i + 1 < n) ? (w + kw + 1) : 0;
        end
        head = bump + 1;
        bump += run >> 3;
      end
      blk = head - 1;
      list_head[cls] = heap_mem[blk];
      heap_mem[blk] = cls;
      g.addr = 18'((blk + 1) * 8);
      g.status = StatusOk;
      return g;
    end
    if (addr >= 8 && addr[2:0] == 3'd0) begin
      blk = (int'(addr) >> 3) - 1;
      if (blk < HeapWords) begin
        cls = heap_mem[blk];
        if (cls != 0 && cls < NumClasses) begin
          heap_mem[blk] = list_head[cls];
          list_head[cls] = blk + 1;
        end
      end
    end
    return g;
  endfunction

  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni) begin
      if (done_i) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected transaction addr %h status %0d", $time,
                   granted_address_i, status_i);
          errors_o++;
        end else begin
          g = grant_q.pop_front();
          if (granted_address_i !== g.addr) begin
            $display("%0t: granted_address expected %h actual %h", $time, g.addr,
                     granted_address_i);
            errors_o++;
          end
          if (status_i !== g.status) begin
            $display("%0t: status expected %0d actual %0d", $time, g.status, status_i);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_i)
        grant_q.push_back(predict_grant(cmd_i, request_bytes_i, payload_address_i));
    end
  end

endmodule

[verif/size_class_free_list_allocator_core_tb.sv]
module size_class_free_list_allocator_core_tb import scfla_pkg::*; ();

  localparam int NumItems = 520;
  localparam int CycleLimit = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        cmd_i = CmdAlloc;
  logic [14:0] request_bytes_i = '0;
  logic [17:0] payload_address_i = '0;
  logic        done_o;
  logic [17:0] granted_address_o;
  logic [1:0]  status_o;
  int          errors;
  int          pending;
  int          cycles = 0;

  logic [17:0] live_q[$];
  int          sent = 0;
  logic [14:0] directed_req[12] = '{15'd0, 15'd1, 15'd56, 15'd120, 15'd1016, 15'd1017,
                                   15'd4088, 15'd32760, 15'd32761, 15'd32767,
                                   15'd7, 15'd2000};

  always #10 clk_i = ~clk_i;

  size_class_free_list_allocator_core DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .request_bytes_i,
    .payload_address_i, .done_o, .granted_address_o, .status_o
  );

  scfla_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .cmd_i, .request_bytes_i,
    .payload_address_i, .done_i(done_o), .granted_address_i(granted_address_o),
    .status_i(status_o), .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (done_o && status_o == StatusOk && granted_address_o != '0)
      live_q.push_back(granted_address_o);
    if (cycles > CycleLimit) begin
      $display("** size_class_free_list_allocator_core: FAILED **");
      $finish;
    end
  end

  task automatic drive_next(int idx);
    int          k;
    int          r;
    logic [17:0] a;
    logic [14:0] rq;
    logic        c;
    a = 18'($urandom());
    rq = 15'($urandom());
    c = CmdAlloc;
    if (idx < 12) begin
      rq = directed_req[idx];
    end else if (idx < 15) begin
      c = CmdFree;
      a = (idx == 12) ? 18'd0 : (idx == 13) ? 18'd4 : 18'h3ffff;
    end else if (idx < 20 && live_q.size() > 0) begin
      c = CmdFree;
      a = live_q.pop_front();
    end else begin
      r = $urandom_range(99);
      if (r < 5) begin
        c = CmdFree;
        if (a[2:0] == 3'd0) a[0] = 1'b1;
      end else if (r < 50 && live_q.size() > 0) begin
        k = $urandom_range(live_q.size() - 1);
        c = CmdFree;
        a = live_q[k];
        live_q.delete(k);
      end else if (r < 78) begin
        rq = 15'($urandom_range(120));
      end else if (r < 92) begin
        rq = 15'($urandom_range(1016));
      end else if (r < 98) begin
        rq = 15'($urandom_range(32760));
      end else begin
        rq = 15'($urandom_range(32767, 32761));
      end
    end
    cmd_i <= c;
    request_bytes_i <= rq;
    payload_address_i <= a;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (sent < NumItems) begin
      @(posedge clk_i);
      if (start_i && !busy_o) sent++;
      if (!start_i || !busy_o) begin
        if (sent == 250 && pending != 0) begin
          start_i <= 1'b0;
        end else if (sent >= NumItems ||
                     (!(sent >= 100 && sent < 200) && $urandom_range(99) < 38)) begin
          start_i <= 1'b0;
        end else begin
          start_i <= 1'b1;
          drive_next(sent);
        end
      end
    end
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("** size_class_free_list_allocator_core: PASSED **");
    end else begin
      $display("** size_class_free_list_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
